/* rtl/core/gce_pkg.sv */
package gce_pkg;

    localparam int M_BITS      = 11;
    localparam int B_BITS      = 4;
    localparam int TAIL_W      = M_BITS + 1;
    localparam int TLEN_W      = 4;
    localparam int DIV_STEPS   = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [M_BITS-1:0] DIVISOR_RESET = 11'd4;

    typedef enum logic [0:0] {
        REG_DIVISOR = 1'b0
    } reg_idx_t;

endpackage

/* rtl/core/golomb_encoder.sv */
// Golomb encoder with truncated-binary remainder.
// Input stream s_axis: one value per request in tdata. Output stream m_axis:
// one codeword chunk per request; tdata carries the chunk bits (right-aligned,
// earliest bit most significant) and the chunk bit count, tlast marks the
// final chunk of a codeword. The divisor m is set over the APB port at byte
// address 0 (reset value 4, zero acts as one); write it only while idle.
// The divider retires 6 quotient bits per cycle unless a full queue holds its
// last step, and it takes a new value as it pushes the last one; the chunk
// emitter sends one chunk per cycle while the output register is free.
// A two-entry queue decouples divider and emitter. When m_axis_tready is low
// the output register holds, the emitter stops, the queue fills and then
// s_axis_tready drops. Reset empties the pipeline and restores the divisor.
module golomb_encoder #(
    parameter int VALUE_BITS = 11,
    parameter int CHUNK_BITS = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // value
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // code_bits, bit_count
    output logic [((CHUNK_BITS + $clog2(CHUNK_BITS + 1) + 7) / 8) * 8-1:0] m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gce_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [gce_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [gce_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam int M       = gce_pkg::M_BITS;
    localparam int CNT_W   = $clog2(CHUNK_BITS + 1);
    localparam int ENTRY_W = VALUE_BITS + 2 * M + gce_pkg::B_BITS;
    localparam int OUT_W   = ((CHUNK_BITS + CNT_W + 7) / 8) * 8;

    logic [M-1:0]          divisor_reg, divisor_next;
    logic                  cfg_wr;
    logic                  addr_hit;

    logic                  push, full, pop, q_valid;
    logic [ENTRY_W-1:0]    push_data, pop_data;
    logic [CHUNK_BITS-1:0] out_code;
    logic [CNT_W-1:0]      out_count;

    assign pready   = 1'b1;
    assign addr_hit = paddr[2] == gce_pkg::REG_DIVISOR;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = addr_hit ? gce_pkg::APB_DATA_W'(divisor_reg) : '0;

    always_comb begin
        divisor_next = divisor_reg;
        if (cfg_wr && addr_hit) begin
            divisor_next = pwdata[M-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= gce_pkg::DIVISOR_RESET;
        end else begin
            divisor_reg <= divisor_next;
        end
    end

    gce_front #(
        .VALUE_BITS (VALUE_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .divisor  (divisor_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_value (s_axis_tdata[VALUE_BITS-1:0]),
        .push     (push),
        .full     (full),
        .entry    (push_data)
    );

    gce_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .valid     (q_valid),
        .pop_data  (pop_data)
    );

    gce_back #(
        .VALUE_BITS (VALUE_BITS),
        .CHUNK_BITS (CHUNK_BITS),
        .ENTRY_W    (ENTRY_W),
        .CNT_W      (CNT_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_code  (out_code),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({out_count, out_code});

endmodule

/* rtl/core/gce_front.sv */
module gce_front #(
    parameter int VALUE_BITS = 11,
    parameter int ENTRY_W    = 37
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [gce_pkg::M_BITS-1:0] divisor,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [VALUE_BITS-1:0]     in_value,
    output logic                      push,
    input  logic                      full,
    output logic [ENTRY_W-1:0]        entry
);

    localparam int M     = gce_pkg::M_BITS;
    localparam int STEPS = gce_pkg::DIV_STEPS;
    localparam int ITERS = (VALUE_BITS + STEPS - 1) / STEPS;
    localparam int DIV_W = ITERS * STEPS;
    localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;

    logic              busy_reg, busy_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [DIV_W-1:0]  num_reg, num_next;
    logic [M-1:0]      rem_reg, rem_next;

    logic [M-1:0]             m_eff;
    logic [gce_pkg::B_BITS-1:0] b_val;
    logic [M-1:0]             first_val;
    logic [DIV_W-1:0]         num_step;
    logic [M-1:0]             rem_step;
    logic                     last_iter;
    logic                     advance;
    logic                     accept;

    always_comb begin
        logic [M-1:0] mm1;
        m_eff = (divisor == '0) ? M'(1) : divisor;
        mm1   = m_eff - M'(1);
        b_val = '0;
        for (int i = 0; i < M; i++) begin
            if (mm1[i]) begin
                b_val = gce_pkg::B_BITS'(i + 1);
            end
        end
        first_val = M'((M + 1)'(1) << b_val) - M'(m_eff);
    end

    always_comb begin
        logic [M:0]       trial;
        logic [M-1:0]     r;
        logic [DIV_W-1:0] n;
        logic             ge;
        r = rem_reg;
        n = num_reg;
        for (int s = 0; s < STEPS; s++) begin
            trial = {r, n[DIV_W-1]};
            ge    = trial >= {1'b0, m_eff};
            r     = ge ? M'(trial - {1'b0, m_eff}) : trial[M-1:0];
            n     = {n[DIV_W-2:0], ge};
        end
        rem_step = r;
        num_step = n;
    end

    assign last_iter = busy_reg && (iter_reg == ITER_W'(ITERS - 1));
    assign push      = last_iter && !full;
    assign advance   = busy_reg && !(last_iter && full);
    assign in_ready  = !busy_reg || push;
    assign accept    = in_valid && in_ready;

    assign entry = {first_val, b_val, rem_step, num_step[VALUE_BITS-1:0]};

    always_comb begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (advance) begin
            iter_next = iter_reg + ITER_W'(1);
            num_next  = num_step;
            rem_next  = rem_step;
            if (push) begin
                busy_next = 1'b0;
            end
        end
        if (accept) begin
            busy_next = 1'b1;
            iter_next = '0;
            num_next  = DIV_W'(in_value);
            rem_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

endmodule

/* rtl/core/gce_queue.sv */
module gce_queue #(
    parameter int WIDTH = 37
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = gce_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full     = count_reg == (AW + 1)'(DEPTH);
    assign valid    = count_reg != '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end

endmodule

/* rtl/core/gce_back.sv */
module gce_back #(
    parameter int VALUE_BITS = 11,
    parameter int CHUNK_BITS = 64,
    parameter int ENTRY_W    = 37,
    parameter int CNT_W      = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  logic [ENTRY_W-1:0]    q_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHUNK_BITS-1:0] out_code,
    output logic [CNT_W-1:0]      out_count,
    output logic                  out_last
);

    localparam int M      = gce_pkg::M_BITS;
    localparam int BB     = gce_pkg::B_BITS;
    localparam int TW     = gce_pkg::TAIL_W;
    localparam int LW     = gce_pkg::TLEN_W;
    localparam int TOT_W  = (VALUE_BITS + 1 > CNT_W) ? VALUE_BITS + 1 : CNT_W;
    localparam int SW     = CHUNK_BITS + TW;

    logic                  active_reg, active_next;
    logic [VALUE_BITS-1:0] ones_reg, ones_next;
    logic [TW-1:0]         tail_reg, tail_next;
    logic [LW-1:0]         tlen_reg, tlen_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CHUNK_BITS-1:0] m_code_reg, m_code_next;
    logic [CNT_W-1:0]      m_cnt_reg, m_cnt_next;
    logic                  m_last_reg, m_last_next;

    logic [VALUE_BITS-1:0] e_q;
    logic [M-1:0]          e_r, e_first, e_code;
    logic [BB-1:0]         e_b, e_nb;
    logic                  e_ge;

    logic [TOT_W-1:0]      total;
    logic                  big, fits, out_free, emit;
    logic [CNT_W-1:0]      cnt;
    logic [LW-1:0]         sh;
    logic [SW-1:0]         ones_mask, str;
    logic [CHUNK_BITS-1:0] chunk;

    assign e_q     = q_data[VALUE_BITS-1:0];
    assign e_r     = q_data[VALUE_BITS +: M];
    assign e_b     = q_data[VALUE_BITS + M +: BB];
    assign e_first = q_data[VALUE_BITS + M + BB +: M];
    assign e_ge    = e_r >= e_first;
    assign e_code  = e_ge ? e_r + e_first : e_r;
    assign e_nb    = e_ge ? e_b : e_b - BB'(1);

    assign total     = TOT_W'(ones_reg) + TOT_W'(tlen_reg);
    assign big       = TOT_W'(ones_reg) >= TOT_W'(CHUNK_BITS);
    assign fits      = total <= TOT_W'(CHUNK_BITS);
    assign cnt       = fits ? CNT_W'(total) : CNT_W'(CHUNK_BITS);
    assign sh        = LW'(total - TOT_W'(cnt));
    assign ones_mask = (SW'(1) << ones_reg) - SW'(1);
    assign str       = (ones_mask << tlen_reg) | SW'(tail_reg);
    assign chunk     = big ? '1 : CHUNK_BITS'(str >> sh);

    assign out_free = !m_valid_reg || out_ready;
    assign emit     = active_reg && out_free;
    assign pop      = q_valid && (!active_reg || (emit && fits));

    always_comb begin
        active_next  = active_reg;
        ones_next    = ones_reg;
        tail_next    = tail_reg;
        tlen_next    = tlen_reg;
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_cnt_next   = m_cnt_reg;
        m_last_next  = m_last_reg;
        if (out_free) begin
            m_valid_next = active_reg;
        end
        if (emit) begin
            m_code_next = chunk;
            m_cnt_next  = cnt;
            m_last_next = fits;
            if (fits) begin
                active_next = 1'b0;
            end else if (big) begin
                ones_next = VALUE_BITS'(TOT_W'(ones_reg) - TOT_W'(CHUNK_BITS));
            end else begin
                ones_next = '0;
                tlen_next = sh;
                tail_next = tail_reg & ((TW'(1) << sh) - TW'(1));
            end
        end
        if (pop) begin
            active_next = 1'b1;
            ones_next   = e_q;
            tail_next   = TW'(e_code);
            tlen_next   = LW'(e_nb) + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
        ones_reg   <= ones_next;
        tail_reg   <= tail_next;
        tlen_reg   <= tlen_next;
        m_code_reg <= m_code_next;
        m_cnt_reg  <= m_cnt_next;
        m_last_reg <= m_last_next;
    end

    assign out_valid = m_valid_reg;
    assign out_code  = m_code_reg;
    assign out_count = m_cnt_reg;
    assign out_last  = m_last_reg;

endmodule

/* tb/golomb_encoder_tb.sv */
`timescale 1ns / 1ps

module golomb_encoder_tb;

    localparam int VALUE_BITS = 11;
    localparam int CHUNK_BITS = 64;
    localparam int S_DATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((CHUNK_BITS + $clog2(CHUNK_BITS + 1) + 7) / 8) * 8;
    localparam int COUNT_W = $clog2(CHUNK_BITS + 1);
    localparam int REG_COUNT = 1;
    localparam logic [gce_pkg::APB_ADDR_W-1:0] DIVISOR_ADDR =
        gce_pkg::APB_ADDR_W'(gce_pkg::REG_DIVISOR) << 2;
    localparam logic [gce_pkg::APB_ADDR_W-1:0] UNMAPPED_ADDR =
        gce_pkg::APB_ADDR_W'(REG_COUNT) << 2;
    localparam int IDLE_PCT = 22;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 18;

    typedef struct packed {
        logic [CHUNK_BITS-1:0] code;
        logic [COUNT_W-1:0]    count;
        logic                  last;
    } chunk_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [S_DATA_W-1:0]            s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]            m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [gce_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [gce_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [gce_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    logic [S_DATA_W-1:0]        values_to_send[$];
    chunk_t                     chunks_due[$];
    logic [gce_pkg::M_BITS-1:0] divisor_model = gce_pkg::DIVISOR_RESET;
    logic                       s_accepted = 1'b0;
    logic                       no_idle = 1'b0;
    logic                       hold_req = 1'b0;
    int                         hold_cycles = 0;
    int                         quiet_cycles = 0;
    int                         mismatches = 0;

    golomb_encoder #(
        .VALUE_BITS(VALUE_BITS),
        .CHUNK_BITS(CHUNK_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),      // value
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),      // code_bits, bit_count
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic predict_codeword(input logic [S_DATA_W-1:0] raw);
        int unsigned v, m, q, r, b, first, code, nb, total, pos, cnt, i, p;
        chunk_t c;
        v = raw[VALUE_BITS-1:0];
        m = (divisor_model == 0) ? 1 : divisor_model;
        q = v / m;
        r = v % m;
        b = 0;
        while ((1 << b) < m) b++;
        first = (1 << b) - m;
        if (r < first) begin
            code = r;
            nb = b - 1;
        end else begin
            code = r + first;
            nb = b;
        end
        total = q + 1 + nb;
        pos = 0;
        while (pos < total) begin
            cnt = (total - pos > CHUNK_BITS) ? CHUNK_BITS : total - pos;
            c.code = '0;
            for (i = 0; i < cnt; i++) begin
                p = pos + i;
                if (p < q)
                    c.code = {c.code[CHUNK_BITS-2:0], 1'b1};
                else if (p == q)
                    c.code = {c.code[CHUNK_BITS-2:0], 1'b0};
                else
                    c.code = {c.code[CHUNK_BITS-2:0], 1'((code >> (nb - 1 - (p - q - 1))) & 1)};
            end
            pos += cnt;
            c.count = COUNT_W'(cnt);
            c.last = (pos >= total);
            chunks_due = {chunks_due, c};
        end
    endtask

    // predict on accepted requests, check accepted chunks
    always @(posedge aclk) begin
        chunk_t want;
        s_accepted <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready)
            predict_codeword(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (chunks_due.size() == 0) begin
                $error("unexpected chunk: code_bits %h bit_count %0d last %b",
                       m_axis_tdata[CHUNK_BITS-1:0],
                       m_axis_tdata[CHUNK_BITS +: COUNT_W], m_axis_tlast);
                mismatches++;
            end else begin
                want = chunks_due.pop_front();
                if (m_axis_tdata[CHUNK_BITS-1:0] !== want.code) begin
                    $error("code_bits: expected %h, actual %h",
                           want.code, m_axis_tdata[CHUNK_BITS-1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[CHUNK_BITS +: COUNT_W] !== want.count) begin
                    $error("bit_count: expected %0d, actual %0d",
                           want.count, m_axis_tdata[CHUNK_BITS +: COUNT_W]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // value driver: hold until accepted, then advance or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !s_accepted)) begin
            if (values_to_send.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= values_to_send.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // chunk receiver with a one-time long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req && hold_cycles < HOLD_OFF_CYCLES) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_register(input logic [gce_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [gce_pkg::APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if ((addr >> 2) == gce_pkg::REG_DIVISOR)
            divisor_model = data[gce_pkg::M_BITS-1:0];
    endtask

    task automatic drain();
        while (values_to_send.size() > 0 || s_axis_tvalid || chunks_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_values(input logic [S_DATA_W-1:0] vals[]);
        foreach (vals[i]) values_to_send = {values_to_send, vals[i]};
        drain();
    endtask

    initial begin
        logic [S_DATA_W-1:0]        raw;
        logic [gce_pkg::M_BITS-1:0] div;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset divisor, extremes and ignored upper value bits
        send_values('{16'd0, 16'd3, 16'd4, 16'd7, 16'd2047, 16'hF805});
        write_register(DIVISOR_ADDR, 32'd1);
        send_values('{16'd0, 16'd2047});
        // zero divisor acts as one; 64 and 65 bit codewords
        write_register(DIVISOR_ADDR, 32'd0);
        send_values('{16'd1, 16'd63, 16'd64});
        write_register(DIVISOR_ADDR, 32'd2047);
        send_values('{16'd0, 16'd1, 16'd2046});
        write_register(DIVISOR_ADDR, 32'd3);
        send_values('{16'd0, 16'd1, 16'd2, 16'd2047});
        // upper write data bits dropped
        write_register(DIVISOR_ADDR, 32'hFFFF_F805);
        send_values('{16'd0, 16'd2, 16'd3, 16'd4});
        write_register(DIVISOR_ADDR, 32'd1024);
        send_values('{16'd1023, 16'd1024});
        // write beyond the register list does nothing
        write_register(UNMAPPED_ADDR, 32'd9);
        send_values('{16'd9});

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: div = gce_pkg::M_BITS'(1);
                1: div = gce_pkg::M_BITS'(2047);
                2, 4: div = gce_pkg::M_BITS'($urandom_range(2, 40));
                default: div = gce_pkg::M_BITS'($urandom_range(2, 2047));
            endcase
            write_register(DIVISOR_ADDR,
                           ($urandom() & ~32'h7FF) | gce_pkg::APB_DATA_W'(div));
            @(posedge aclk);
            no_idle <= (ph == 5);
            hold_req <= (ph == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                raw = S_DATA_W'($urandom_range(0, 16'hFFFF));
                if ($urandom_range(3) == 0)
                    raw[VALUE_BITS-1:0] = VALUE_BITS'($urandom_range(0, 63));
                values_to_send = {values_to_send, raw};
            end
            drain();
        end
        no_idle <= 1'b0;
        drain();

        if (chunks_due.size() > 0) begin
            $error("%0d expected chunks never arrived", chunks_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
